// ===== rtl/core/auto_shift_key_resolver_unit_defines.svh =====
// Assertion macros shared by the checker.
`ifndef AUTO_SHIFT_KEY_RESOLVER_UNIT_DEFINES_SVH
`define AUTO_SHIFT_KEY_RESOLVER_UNIT_DEFINES_SVH
// Assert prop on every rising clock edge outside reset.
`define ASKR_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`endif

// ===== rtl/core/askr_pkg.sv =====
package askr_pkg;
  typedef enum logic [1:0] {
    CMD_PRESS = 2'd0, CMD_RELEASE = 2'd1, CMD_TICK = 2'd2, CMD_OTHER = 2'd3
  } cmd_e;
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0, MODE_PENDING = 2'd1, MODE_NORMAL = 2'd2, MODE_SHIFTED = 2'd3
  } mode_e;
  typedef enum logic [2:0] {
    CFG_ENABLE = 3'd0, CFG_HOLD = 3'd1, CFG_LETTERS = 3'd2, CFG_DIGITS = 3'd3,
    CFG_PUNCT = 3'd4
  } cfg_e;
  localparam logic [9:0] HoldMax = 10'd1000;
  localparam logic [9:0] HoldReset = 10'd175;
  // Classified command passed from front to back.
  typedef struct packed {
    cmd_e        cmd;
    logic        shiftable;
    logic [7:0]  key;
    logic [15:0] code;
    logic        remote;
  } op_t;
  // One result word.
  typedef struct packed {
    logic        kind;
    logic [15:0] code;
    logic        pressed;
    logic        shifted;
    logic        remote;
    logic        accepted;
    logic        last;
  } res_t;
  function automatic logic usage_shiftable(input logic [7:0] u, input logic let_en,
                                            input logic dig_en, input logic pun_en);
    logic r;
    r = (let_en && u >= 8'h04 && u <= 8'h1D) || (dig_en && u >= 8'h1E && u <= 8'h27) ||
        (pun_en && ((u >= 8'h2D && u <= 8'h31) || (u >= 8'h33 && u <= 8'h38)));
    return r;
  endfunction
endpackage

// ===== rtl/core/askr_fifo.sv =====
module askr_fifo import askr_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;
  logic [Width-1:0] mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0] cnt_q;
  logic do_push, do_pop;
  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (do_pop)  rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
    end
  end
endmodule

// ===== rtl/core/askr_front.sv =====
module askr_front import askr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  key_number_i,
  input  logic [15:0] key_code_i,
  input  logic        code_is_basic_i,
  input  logic [7:0]  usage_code_i,
  input  logic        code_is_modifier_i,
  input  logic        from_remote_i,
  output op_t         op_o,
  output logic        enable_o,
  output logic [9:0]  hold_o
);
  logic en_q, let_q, dig_q, pun_q;
  logic [9:0] hold_q;
  logic [9:0] hv;
  assign cfg_ready = 1'b1;
  assign hv = cfg_data_i[9:0];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b1; let_q <= 1'b1; dig_q <= 1'b1; pun_q <= 1'b1; hold_q <= HoldReset;
    end else if (cfg_valid) begin
      unique case (cfg_index_i)
        CFG_ENABLE:  en_q <= cfg_data_i[0];
        CFG_HOLD:    if (hv != '0 && hv <= HoldMax) hold_q <= hv;
        CFG_LETTERS: let_q <= cfg_data_i[0];
        CFG_DIGITS:  dig_q <= cfg_data_i[0];
        CFG_PUNCT:   pun_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end
  assign enable_o = en_q;
  assign hold_o = hold_q;
  always_comb begin
    op_o.cmd = cmd_e'(cmd_i);
    op_o.shiftable = en_q && code_is_basic_i && !code_is_modifier_i &&
                     usage_shiftable(usage_code_i, let_q, dig_q, pun_q);
    op_o.key = key_number_i;
    op_o.code = key_code_i;
    op_o.remote = from_remote_i;
  end
endmodule

// ===== rtl/core/askr_back.sv =====
module askr_back import askr_pkg::*; #(
  parameter int Slots = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       enable_i,
  input  logic [9:0] hold_i,
  input  op_t        op_i,
  input  logic       op_empty_i,
  output logic       op_pop_o,
  output res_t       res_o,
  output logic       res_push_o,
  input  logic       res_full_i
);
  localparam int Sw = (Slots > 1) ? $clog2(Slots) : 1;
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_SCAN = 4'b0010, ST_FIN = 4'b0100, ST_ACK = 4'b1000
  } state_e;
  state_e st_q, st_d;
  mode_e mode_q [Slots];
  logic [7:0] key_q [Slots];
  logic [15:0] code_q [Slots];
  logic rem_q [Slots];
  logic [31:0] pt_q [Slots];
  logic [31:0] now_q;
  logic [Sw-1:0] idx_q;
  logic [Sw:0] free_q, found_q;   // MSB set means none
  logic acc_q;
  logic last_idx, emit, cur_pending, hit, elapsed_ok;
  logic [31:0] elapsed;
  op_t op;
  assign op = op_i;
  assign last_idx = (idx_q == Sw'(Slots - 1));
  assign cur_pending = (mode_q[idx_q] == MODE_PENDING);
  assign elapsed = now_q - pt_q[idx_q];
  assign elapsed_ok = elapsed >= {22'd0, hold_i};
  assign hit = (mode_q[idx_q] != MODE_IDLE) && key_q[idx_q] == op.key;
  always_comb begin
    emit = 1'b0;
    unique case (op.cmd)
      CMD_PRESS:   emit = op.shiftable && cur_pending && key_q[idx_q] != op.key;
      CMD_RELEASE: emit = 1'b0;
      CMD_TICK:    emit = enable_i && cur_pending && elapsed_ok;
      CMD_OTHER:   emit = cur_pending;
      default:     emit = 1'b0;
    endcase
  end
  always_comb begin
    res_o = '0;
    res_push_o = 1'b0;
    op_pop_o = 1'b0;
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (!op_empty_i) st_d = ST_SCAN;
      ST_SCAN: begin
        if (emit) begin
          res_o.code = code_q[idx_q];
          res_o.pressed = 1'b1;
          res_o.shifted = (op.cmd == CMD_TICK);
          res_o.remote = rem_q[idx_q];
          res_push_o = !res_full_i;
        end
        if ((!emit || !res_full_i) && last_idx) st_d = ST_FIN;
      end
      ST_FIN: begin
        if (op.cmd == CMD_RELEASE && !found_q[Sw]) begin
          res_o.code = code_q[found_q[Sw-1:0]];
          res_o.pressed = (mode_q[found_q[Sw-1:0]] == MODE_PENDING);
          res_o.shifted = (mode_q[found_q[Sw-1:0]] == MODE_SHIFTED);
          res_o.remote = rem_q[found_q[Sw-1:0]];
          res_push_o = !res_full_i;
          if (!res_full_i && mode_q[found_q[Sw-1:0]] != MODE_PENDING) st_d = ST_ACK;
        end else begin
          st_d = ST_ACK;
        end
      end
      ST_ACK: begin
        res_o.kind = 1'b1;
        res_o.accepted = acc_q;
        res_o.last = 1'b1;
        res_push_o = !res_full_i;
        op_pop_o = !res_full_i;
        if (!res_full_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; idx_q <= '0; free_q <= '1; found_q <= '1; acc_q <= 1'b0;
      now_q <= '0;
      for (int i = 0; i < Slots; i++) begin
        mode_q[i] <= MODE_IDLE; key_q[i] <= '0; code_q[i] <= '0; rem_q[i] <= 1'b0;
        pt_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      unique case (st_q)
        ST_IDLE: if (!op_empty_i) begin
          idx_q <= '0; free_q <= '1; found_q <= '1; acc_q <= 1'b0;
          if (op.cmd == CMD_TICK) now_q <= now_q + 32'd1;
        end
        ST_SCAN: if (!emit || !res_full_i) begin
          if (emit) mode_q[idx_q] <= (op.cmd == CMD_TICK) ? MODE_SHIFTED : MODE_NORMAL;
          if (mode_q[idx_q] == MODE_IDLE && free_q[Sw]) free_q <= {1'b0, idx_q};
          if (hit && found_q[Sw]) found_q <= {1'b0, idx_q};
          if (!last_idx) idx_q <= idx_q + 1'b1;
        end
        ST_FIN: begin
          if (op.cmd == CMD_PRESS && op.shiftable && !free_q[Sw]) begin
            mode_q[free_q[Sw-1:0]] <= MODE_PENDING;
            key_q[free_q[Sw-1:0]] <= op.key;
            code_q[free_q[Sw-1:0]] <= op.code;
            rem_q[free_q[Sw-1:0]] <= op.remote;
            pt_q[free_q[Sw-1:0]] <= now_q;
            acc_q <= 1'b1;
          end
          if (op.cmd == CMD_RELEASE && !found_q[Sw] && !res_full_i) begin
            if (mode_q[found_q[Sw-1:0]] == MODE_PENDING) begin
              mode_q[found_q[Sw-1:0]] <= MODE_NORMAL;
            end else begin
              mode_q[found_q[Sw-1:0]] <= MODE_IDLE;
              key_q[found_q[Sw-1:0]] <= '0;
              code_q[found_q[Sw-1:0]] <= '0;
              rem_q[found_q[Sw-1:0]] <= 1'b0;
              pt_q[found_q[Sw-1:0]] <= '0;
              acc_q <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/core/auto_shift_key_resolver_unit.sv =====
// Auto shift tap/hold resolver.
// Input channel: queue style, push with full; a word is taken when push
// is high and full low. Fields: cmd, key number, keycode, class flags.
// Result channel: queue style, empty with pop; the oldest result stays on
// the result ports while empty is low and leaves on pop.
// Config channel: cfg_valid/cfg_ready with index and data, always ready.
// Each command produces zero or more key events followed by one acknowledge
// word with last set.
// Flow: a front queue holds two commands; the back scans the slot table
// one slot a cycle while no event waits on a full result queue, then
// finishes and acknowledges, and starts the next command only after the
// acknowledge word is pushed.
// Reset clears the slot table, the millisecond clock, both queues and the
// config registers to their defaults; no clearing pass is needed.
// When the receiver stalls, the result queue fills, the back halts mid scan,
// and full rises once the command queue is full too; nothing is dropped.
module auto_shift_key_resolver_unit import askr_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  key_number_i,
  input  logic [15:0] key_code_i,
  input  logic        code_is_basic_i,
  input  logic [7:0]  usage_code_i,
  input  logic        code_is_modifier_i,
  input  logic        from_remote_i,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [15:0] event_code_o,
  output logic        event_pressed_o,
  output logic        event_shifted_o,
  output logic        event_remote_o,
  output logic        accepted_o,
  output logic        last_o
);
  op_t op_in, op_out;
  res_t res_in, res_out;
  logic enable, op_empty, op_pop, res_push, res_full;
  logic [9:0] hold;

  // Classify and hold config.
  askr_front u_front (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i,
    .cmd_i, .key_number_i, .key_code_i, .code_is_basic_i, .usage_code_i,
    .code_is_modifier_i, .from_remote_i,
    .op_o(op_in), .enable_o(enable), .hold_o(hold)
  );

  // Decouple front from back.
  askr_fifo #(.Width($bits(op_t)), .Depth(2)) u_opq (
    .clk_i, .rst_ni, .push_i(push), .data_i(op_in), .full_o(full),
    .pop_i(op_pop), .data_o(op_out), .empty_o(op_empty)
  );

  askr_back #(.Slots(SLOTS)) u_back (
    .clk_i, .rst_ni, .enable_i(enable), .hold_i(hold), .op_i(op_out),
    .op_empty_i(op_empty), .op_pop_o(op_pop), .res_o(res_in),
    .res_push_o(res_push), .res_full_i(res_full)
  );

  // Hold results until popped.
  askr_fifo #(.Width($bits(res_t)), .Depth(2)) u_resq (
    .clk_i, .rst_ni, .push_i(res_push), .data_i(res_in), .full_o(res_full),
    .pop_i(pop), .data_o(res_out), .empty_o(empty)
  );

  assign kind_o          = res_out.kind;
  assign event_code_o    = res_out.code;
  assign event_pressed_o = res_out.pressed;
  assign event_shifted_o = res_out.shifted;
  assign event_remote_o  = res_out.remote;
  assign accepted_o      = res_out.accepted;
  assign last_o          = res_out.last;
endmodule

// ===== rtl/core/askr_checker.sv =====
`include "auto_shift_key_resolver_unit_defines.svh"
module askr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input logic kind_o,
  input logic last_o,
  input logic accepted_o,
  input logic event_pressed_o,
  input logic [15:0] event_code_o
);
  `ASKR_ASSERT(a_last_is_ack, clk_i, rst_ni, !empty |-> (kind_o == last_o), "last mismatch")
  `ASKR_ASSERT(a_evt_no_acc, clk_i, rst_ni, (!empty && !kind_o) |-> !accepted_o, "event acc")
  `ASKR_ASSERT(a_ack_clean, clk_i, rst_ni, (!empty && kind_o) |-> (event_code_o == 16'd0 && !event_pressed_o), "ack dirty")
  `ASKR_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(event_code_o)), "stall drop")
endmodule

bind auto_shift_key_resolver_unit askr_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .kind_o, .last_o, .accepted_o, .event_pressed_o,
  .event_code_o
);
